[design/lqr_ios_pkg.sv]
// shared types and constants of the lqr integral observer step unit
package lqr_ios_pkg;

    localparam int COEF_WIDTH   = 21;
    localparam int SAMPLE_WIDTH = 32;
    localparam int STATE_WIDTH  = 48;
    localparam int FRAC_BITS    = 16;
    localparam int ROW_WIDTH    = 3 * COEF_WIDTH;
    localparam int ACC_WIDTH    = STATE_WIDTH + COEF_WIDTH + 3;
    localparam int INT_WIDTH    = STATE_WIDTH + 2;
    localparam int NUM_TERMS    = 22;
    localparam int TERM_W       = $clog2(NUM_TERMS);
    localparam int BIT_W        = $clog2(COEF_WIDTH);
    localparam int NUM_ROWS     = 7;

    // schedule positions of the product terms that close a sum
    localparam logic [TERM_W-1:0] TERM_DRIVE_END = TERM_W'(3);
    localparam logic [TERM_W-1:0] TERM_INNOV_END = TERM_W'(6);
    localparam logic [TERM_W-1:0] TERM_NX1_END   = TERM_W'(11);
    localparam logic [TERM_W-1:0] TERM_NX2_END   = TERM_W'(16);
    localparam logic [TERM_W-1:0] TERM_NX3_END   = TERM_W'(21);

    localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        CFG_G_ROW1 = 3'd0,
        CFG_G_ROW2 = 3'd1,
        CFG_G_ROW3 = 3'd2,
        CFG_H_COL  = 3'd3,
        CFG_C_ROW  = 3'd4,
        CFG_KE_COL = 3'd5,
        CFG_K_ROW  = 3'd6,
        CFG_KI     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_SAT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_INTEG,
        OP_STATE,
        OP_DRIVE,
        OP_INNOV
    } t_opnd;

endpackage

[design/lqr_integral_observer_step_unit.sv]
// top level of the lqr servo step with error integrator and three-state observer
//
// usage
//   s_axis carries one sample pair per transfer: reference and measurement,
//   both signed Q16.16. m_axis returns the saturated drive u (Q16.16) with a
//   flag in tuser that is set when the drive, the integrator or a next state
//   clamped. i_cfg_* writes the coefficient registers; the user must write
//   them only while the unit is idle, the unit itself does not enforce this.
//   timing
//   all 22 products run through one bit-serial multiply-accumulate unit, one
//   coefficient bit per cycle; each sum is then saturated in its own step, and
//   the result is posted. A new sample is taken once the previous step is posted.
//   reset
//   i_rst_n low clears the control and coefficient registers, the estimates and the integrator.
//   stall
//   the result waits in an output register; s_axis_tready comes back as soon
//   as it is posted. If the previous result is still held, the unit waits
//   with the finished step until m_axis_tready takes it.
module lqr_integral_observer_step_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // reference [31:0], measurement [63:32]
    input  logic [2*lqr_ios_pkg::SAMPLE_WIDTH-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // drive [31:0]
    output logic [lqr_ios_pkg::SAMPLE_WIDTH-1:0]      m_axis_tdata,
    // saturated [0]
    output logic                                      m_axis_tuser,
    input  logic                                      i_cfg_we,
    input  logic [2:0]                                i_cfg_idx,
    input  logic [lqr_ios_pkg::ROW_WIDTH-1:0]         i_cfg_data
);

    localparam int CW  = lqr_ios_pkg::COEF_WIDTH;
    localparam int SW  = lqr_ios_pkg::SAMPLE_WIDTH;
    localparam int XW  = lqr_ios_pkg::STATE_WIDTH;
    localparam int AW  = lqr_ios_pkg::ACC_WIDTH;
    localparam int IW  = lqr_ios_pkg::INT_WIDTH;
    localparam int TW  = lqr_ios_pkg::TERM_W;
    localparam int BW  = lqr_ios_pkg::BIT_W;

    lqr_ios_pkg::t_state r_state, n_state;
    logic [TW-1:0] r_p, n_p;
    logic [BW-1:0] r_j, n_j;

    logic [lqr_ios_pkg::ROW_WIDTH-1:0] r_cfg [lqr_ios_pkg::NUM_ROWS];
    logic [CW-1:0] r_ki;

    logic signed [XW-1:0] r_x [3];
    logic signed [XW-1:0] r_nx [3];
    logic signed [XW-1:0] r_integ;
    logic signed [XW-1:0] r_e;
    logic signed [SW-1:0] r_u;
    logic signed [SW-1:0] r_meas;
    logic                 r_flag;

    logic signed [AW-1:0] r_acc, n_acc;
    logic signed [AW-1:0] r_m, n_m;
    logic [CW-1:0]        r_c, n_c;

    logic                 r_out_valid, n_out_valid;
    logic [SW-1:0]        r_out_drive;
    logic                 r_out_sat;

    // term decode
    lqr_ios_pkg::t_cfg_idx w_row;
    lqr_ios_pkg::t_opnd    w_opnd;
    logic [1:0]            w_k;
    logic                  w_neg;
    logic                  w_start;
    logic                  w_init_meas;
    logic [CW-1:0]         w_coef;
    logic signed [AW-1:0]  w_operand;

    logic                  w_first;
    logic                  w_last;
    logic                  w_cbit;
    logic                  w_sub;
    logic signed [AW-1:0]  w_mult;
    logic signed [AW-1:0]  w_base;
    logic signed [AW-1:0]  w_init;

    logic signed [IW-1:0]  w_int_sum;
    logic                  w_int_ovf;
    logic signed [XW-1:0]  w_int_sat;

    logic signed [AW-1:0]  w_shift;
    logic                  w_ovf_state;
    logic                  w_ovf_sample;
    logic signed [XW-1:0]  w_sat_state;
    logic signed [SW-1:0]  w_sat_sample;

    logic w_in_xfer;
    logic w_post;

    assign s_axis_tready = (r_state == lqr_ios_pkg::ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_sat;

    // schedule of product terms
    always_comb begin
        w_row       = lqr_ios_pkg::CFG_KI;
        w_opnd      = lqr_ios_pkg::OP_INTEG;
        w_k         = 2'd0;
        w_neg       = 1'b0;
        w_start     = 1'b0;
        w_init_meas = 1'b0;
        case (r_p)
            TW'(0): begin
                w_start = 1'b1;
            end
            TW'(1), TW'(2), TW'(3): begin
                w_row  = lqr_ios_pkg::CFG_K_ROW;
                w_opnd = lqr_ios_pkg::OP_STATE;
                w_k    = 2'(r_p - TW'(1));
                w_neg  = 1'b1;
            end
            TW'(4), TW'(5), TW'(6): begin
                w_row       = lqr_ios_pkg::CFG_C_ROW;
                w_opnd      = lqr_ios_pkg::OP_STATE;
                w_k         = 2'(r_p - TW'(4));
                w_neg       = 1'b1;
                w_start     = (r_p == TW'(4));
                w_init_meas = 1'b1;
            end
            TW'(7): begin
                w_row   = lqr_ios_pkg::CFG_H_COL;
                w_opnd  = lqr_ios_pkg::OP_DRIVE;
                w_start = 1'b1;
            end
            TW'(8), TW'(9), TW'(10): begin
                w_row  = lqr_ios_pkg::CFG_G_ROW1;
                w_opnd = lqr_ios_pkg::OP_STATE;
                w_k    = 2'(r_p - TW'(8));
            end
            TW'(11): begin
                w_row  = lqr_ios_pkg::CFG_KE_COL;
                w_opnd = lqr_ios_pkg::OP_INNOV;
            end
            TW'(12): begin
                w_row   = lqr_ios_pkg::CFG_H_COL;
                w_opnd  = lqr_ios_pkg::OP_DRIVE;
                w_k     = 2'd1;
                w_start = 1'b1;
            end
            TW'(13), TW'(14), TW'(15): begin
                w_row  = lqr_ios_pkg::CFG_G_ROW2;
                w_opnd = lqr_ios_pkg::OP_STATE;
                w_k    = 2'(r_p - TW'(13));
            end
            TW'(16): begin
                w_row  = lqr_ios_pkg::CFG_KE_COL;
                w_opnd = lqr_ios_pkg::OP_INNOV;
                w_k    = 2'd1;
            end
            TW'(17): begin
                w_row   = lqr_ios_pkg::CFG_H_COL;
                w_opnd  = lqr_ios_pkg::OP_DRIVE;
                w_k     = 2'd2;
                w_start = 1'b1;
            end
            TW'(18), TW'(19), TW'(20): begin
                w_row  = lqr_ios_pkg::CFG_G_ROW3;
                w_opnd = lqr_ios_pkg::OP_STATE;
                w_k    = 2'(r_p - TW'(18));
            end
            TW'(21): begin
                w_row  = lqr_ios_pkg::CFG_KE_COL;
                w_opnd = lqr_ios_pkg::OP_INNOV;
                w_k    = 2'd2;
            end
            default: begin
                w_start = 1'b1;
            end
        endcase
    end

    always_comb begin
        case (w_row)
            lqr_ios_pkg::CFG_KI: w_coef = r_ki;
            default:             w_coef = r_cfg[w_row][w_k*CW +: CW];
        endcase
    end

    always_comb begin
        case (w_opnd)
            lqr_ios_pkg::OP_INTEG: w_operand = AW'(r_integ);
            lqr_ios_pkg::OP_STATE: w_operand = AW'(r_x[w_k]);
            lqr_ios_pkg::OP_DRIVE: w_operand = AW'(r_u);
            lqr_ios_pkg::OP_INNOV: w_operand = AW'(r_e);
            default:               w_operand = AW'(r_integ);
        endcase
    end

    // bit-serial multiply-accumulate, coefficient lsb first, sign bit last
    assign w_first = (r_j == '0);
    assign w_last  = (r_j == BW'(CW - 1));
    assign w_mult  = w_first ? w_operand : r_m;
    assign w_cbit  = w_first ? w_coef[0] : r_c[0];
    assign w_sub   = w_last ? !w_neg : w_neg;
    assign w_init  = w_init_meas ? (AW'(r_meas) <<< lqr_ios_pkg::FRAC_BITS) : '0;
    assign w_base  = (w_first && w_start) ? w_init : r_acc;

    always_comb begin
        if (!w_cbit) begin
            n_acc = w_base;
        end else if (w_sub) begin
            n_acc = w_base - w_mult;
        end else begin
            n_acc = w_base + w_mult;
        end
        n_m = w_mult <<< 1;
        n_c = {1'b0, (w_first ? w_coef[CW-1:1] : r_c[CW-1:1])};
    end

    // integrator update on the input transfer
    assign w_int_sum = IW'(r_integ) + IW'($signed(s_axis_tdata[SW-1:0]))
                     - IW'($signed(s_axis_tdata[2*SW-1:SW]));
    assign w_int_ovf = !((&w_int_sum[IW-1:XW-1]) || !(|w_int_sum[IW-1:XW-1]));
    assign w_int_sat = w_int_ovf ? (w_int_sum[IW-1] ? lqr_ios_pkg::STATE_MIN
                                                     : lqr_ios_pkg::STATE_MAX)
                                 : w_int_sum[XW-1:0];

    // scaling and saturation of a finished sum
    assign w_shift      = r_acc >>> lqr_ios_pkg::FRAC_BITS;
    assign w_ovf_state  = !((&w_shift[AW-1:XW-1]) || !(|w_shift[AW-1:XW-1]));
    assign w_ovf_sample = !((&w_shift[AW-1:SW-1]) || !(|w_shift[AW-1:SW-1]));
    assign w_sat_state  = w_ovf_state ? (r_acc[AW-1] ? lqr_ios_pkg::STATE_MIN
                                                     : lqr_ios_pkg::STATE_MAX)
                                      : w_shift[XW-1:0];
    assign w_sat_sample = w_ovf_sample ? (r_acc[AW-1] ? lqr_ios_pkg::SAMPLE_MIN
                                                      : lqr_ios_pkg::SAMPLE_MAX)
                                       : w_shift[SW-1:0];

    assign w_post = (r_state == lqr_ios_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            lqr_ios_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = lqr_ios_pkg::ST_MAC;
                    n_p     = '0;
                    n_j     = '0;
                end
            end
            lqr_ios_pkg::ST_MAC: begin
                if (w_last) begin
                    n_j = '0;
                    if (r_p == lqr_ios_pkg::TERM_DRIVE_END || r_p == lqr_ios_pkg::TERM_INNOV_END
                        || r_p == lqr_ios_pkg::TERM_NX1_END || r_p == lqr_ios_pkg::TERM_NX2_END
                        || r_p == lqr_ios_pkg::TERM_NX3_END) begin
                        n_state = lqr_ios_pkg::ST_SAT;
                    end else begin
                        n_p = r_p + TW'(1);
                    end
                end else begin
                    n_j = r_j + BW'(1);
                end
            end
            lqr_ios_pkg::ST_SAT: begin
                if (r_p == lqr_ios_pkg::TERM_NX3_END) begin
                    n_state = lqr_ios_pkg::ST_DONE;
                end else begin
                    n_state = lqr_ios_pkg::ST_MAC;
                    n_p     = r_p + TW'(1);
                end
            end
            lqr_ios_pkg::ST_DONE: begin
                if (w_post) begin
                    n_state     = lqr_ios_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = lqr_ios_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lqr_ios_pkg::ST_IDLE;
            r_p         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lqr_ios_pkg::NUM_ROWS; i++) begin
                r_cfg[i] <= '0;
            end
            r_ki <= '0;
        end else if (i_cfg_we) begin
            case (lqr_ios_pkg::t_cfg_idx'(i_cfg_idx))
                lqr_ios_pkg::CFG_KI: r_ki <= i_cfg_data[CW-1:0];
                default:             r_cfg[i_cfg_idx] <= i_cfg_data;
            endcase
        end
    end

    // loop state: estimates, integrator, flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_x[i] <= '0;
            end
            r_integ <= '0;
            r_flag  <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_integ <= w_int_sat;
                r_flag  <= w_int_ovf;
            end else if (r_state == lqr_ios_pkg::ST_SAT) begin
                if (r_p != lqr_ios_pkg::TERM_INNOV_END) begin
                    r_flag <= r_flag
                            | ((r_p == lqr_ios_pkg::TERM_DRIVE_END) ? w_ovf_sample : w_ovf_state);
                end
            end
            if (w_post) begin
                for (int i = 0; i < 3; i++) begin
                    r_x[i] <= r_nx[i];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_meas <= $signed(s_axis_tdata[2*SW-1:SW]);
        end
        if (r_state == lqr_ios_pkg::ST_MAC) begin
            r_acc <= n_acc;
            r_m   <= n_m;
            r_c   <= n_c;
        end
        if (r_state == lqr_ios_pkg::ST_SAT) begin
            case (r_p)
                lqr_ios_pkg::TERM_DRIVE_END: r_u     <= w_sat_sample;
                lqr_ios_pkg::TERM_INNOV_END: r_e     <= w_sat_state;
                lqr_ios_pkg::TERM_NX1_END:   r_nx[0] <= w_sat_state;
                lqr_ios_pkg::TERM_NX2_END:   r_nx[1] <= w_sat_state;
                lqr_ios_pkg::TERM_NX3_END:   r_nx[2] <= w_sat_state;
                default:                     r_e     <= r_e;
            endcase
        end
        if (w_post) begin
            r_out_drive <= r_u;
            r_out_sat   <= r_flag;
        end
    end

endmodule

[design/lqr_ios_chk.sv]
// port-level checker for the lqr integral observer step unit, with its bind
module lqr_ios_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [2*lqr_ios_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [lqr_ios_pkg::SAMPLE_WIDTH-1:0]   m_axis_tdata,
    input logic                                   m_axis_tuser,
    input logic                                   i_cfg_we,
    input logic [2:0]                             i_cfg_idx,
    input logic [lqr_ios_pkg::ROW_WIDTH-1:0]      i_cfg_data
);

    // one step at a time: input closes after a transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a new result appears exactly when the unit reopens its input
    a_post_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
        else $error("result posted without finishing a step");

    // nothing is produced while idle with no step in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && $past(s_axis_tready) && !$past(m_axis_tvalid) |-> !m_axis_tvalid)
        else $error("result without an input transfer");

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind lqr_integral_observer_step_unit lqr_ios_chk u_lqr_ios_chk (.*);

[tb/lqr_integral_observer_step_unit_tb.sv]
// testbench of the lqr integral observer step unit: predicts drive and clamp flag per sample
module lqr_integral_observer_step_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEF_WIDTH   = lqr_ios_pkg::COEF_WIDTH;
    localparam int SAMPLE_WIDTH = lqr_ios_pkg::SAMPLE_WIDTH;
    localparam int STATE_WIDTH  = lqr_ios_pkg::STATE_WIDTH;
    localparam int FRAC_BITS    = lqr_ios_pkg::FRAC_BITS;
    localparam int ROW_WIDTH    = lqr_ios_pkg::ROW_WIDTH;
    localparam int NUM_ROWS     = lqr_ios_pkg::NUM_ROWS;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = lqr_ios_pkg::SAMPLE_MAX;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = lqr_ios_pkg::SAMPLE_MIN;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] drive;
        logic                    clipped;
    } t_drive_result;

    typedef enum int {
        MIX_SMALL,
        MIX_FULL,
        MIX_EDGE
    } t_coef_mix;

    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << FRAC_BITS);

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [2*SAMPLE_WIDTH-1:0]    s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [SAMPLE_WIDTH-1:0]      m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         i_cfg_we;
    logic [2:0]                   i_cfg_idx;
    logic [ROW_WIDTH-1:0]         i_cfg_data;

    logic [ROW_WIDTH-1:0]          coef_row [NUM_ROWS];
    logic signed [COEF_WIDTH-1:0]  ki_gain;
    logic signed [STATE_WIDTH-1:0] est_x [3];
    logic signed [STATE_WIDTH-1:0] err_integ;

    t_drive_result drive_q [$];
    int            err_cnt = 0;
    bit            idle_on = 1'b1;

    lqr_integral_observer_step_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_wide clamp_to(input t_wide v, input int w, output bit hit);
        t_wide top;
        t_wide bot;
        top = (t_wide'(1) << (w - 1)) - t_wide'(1);
        bot = -top - t_wide'(1);
        hit = 1'b0;
        if (v > top) begin
            hit = 1'b1;
            return top;
        end
        if (v < bot) begin
            hit = 1'b1;
            return bot;
        end
        return v;
    endfunction

    function automatic t_wide coef_of(input logic [ROW_WIDTH-1:0] row, input int k);
        logic signed [COEF_WIDTH-1:0] c;
        c = row[k*COEF_WIDTH +: COEF_WIDTH];
        return t_wide'(c);
    endfunction

    function automatic logic [ROW_WIDTH-1:0] pack3(input logic [COEF_WIDTH-1:0] c1, c2, c3);
        return {c3, c2, c1};
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] rand_coef(input t_coef_mix mix);
        logic signed [COEF_WIDTH-1:0] c;
        case (mix)
            MIX_SMALL: begin
                c = COEF_WIDTH'($urandom_range(32768));
                c = c - COEF_WIDTH'(16384);
            end
            MIX_FULL: begin
                c = COEF_WIDTH'($urandom);
            end
            default: begin
                case ($urandom_range(4))
                    0: c = COEF_MAX;
                    1: c = COEF_MIN;
                    2: c = '0;
                    3: c = '1;
                    default: c = COEF_ONE;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        logic signed [SAMPLE_WIDTH-1:0] s;
        case ($urandom_range(9))
            0, 1, 2, 3: s = $urandom;
            4, 5, 6, 7: s = $urandom_range(2097152) - 1048576;
            8: s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            default: s = $urandom_range(64) - 32;
        endcase
        return s;
    endfunction

    // one control step: integrator, drive, innovation, next estimates
    task automatic predict_step(input logic signed [SAMPLE_WIDTH-1:0] setpoint, meas);
        t_wide         acc;
        t_wide         integ;
        t_wide         drive;
        t_wide         innov;
        t_wide         nx [3];
        bit            hit;
        bit            clipped;
        t_drive_result res;
        clipped = 1'b0;
        acc = t_wide'(err_integ) + t_wide'(setpoint) - t_wide'(meas);
        integ = clamp_to(acc, STATE_WIDTH, hit);
        clipped |= hit;
        acc = integ * t_wide'(ki_gain);
        for (int k = 0; k < 3; k++) begin
            acc -= t_wide'(est_x[k]) * coef_of(coef_row[lqr_ios_pkg::CFG_K_ROW], k);
        end
        drive = clamp_to(acc >>> FRAC_BITS, SAMPLE_WIDTH, hit);
        clipped |= hit;
        acc = t_wide'(meas) <<< FRAC_BITS;
        for (int k = 0; k < 3; k++) begin
            acc -= t_wide'(est_x[k]) * coef_of(coef_row[lqr_ios_pkg::CFG_C_ROW], k);
        end
        // innovation clamp does not raise the flag
        innov = clamp_to(acc >>> FRAC_BITS, STATE_WIDTH, hit);
        for (int i = 0; i < 3; i++) begin
            acc = drive * coef_of(coef_row[lqr_ios_pkg::CFG_H_COL], i);
            for (int k = 0; k < 3; k++) begin
                acc += t_wide'(est_x[k])
                     * coef_of(coef_row[int'(lqr_ios_pkg::CFG_G_ROW1) + i], k);
            end
            acc += innov * coef_of(coef_row[lqr_ios_pkg::CFG_KE_COL], i);
            nx[i] = clamp_to(acc >>> FRAC_BITS, STATE_WIDTH, hit);
            clipped |= hit;
        end
        for (int i = 0; i < 3; i++) begin
            est_x[i] = nx[i][STATE_WIDTH-1:0];
        end
        err_integ = integ[STATE_WIDTH-1:0];
        res.drive = drive[SAMPLE_WIDTH-1:0];
        res.clipped = clipped;
        drive_q.push_back(res);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] setpoint, meas);
        int holdoff;
        holdoff = 0;
        @(negedge i_clk);
        if (idle_on) begin
            if ($urandom_range(99) < 4) begin
                holdoff = $urandom_range(480, 1);
            end
            while ($urandom_range(99) < 11) begin
                holdoff++;
            end
        end
        repeat (holdoff) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, setpoint};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_step(setpoint, meas);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input lqr_ios_pkg::t_cfg_idx idx,
                             input logic [ROW_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == lqr_ios_pkg::CFG_KI) begin
            ki_gain = value[COEF_WIDTH-1:0];
        end else begin
            coef_row[idx] = value;
        end
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_uniform(input logic [COEF_WIDTH-1:0] c1, c2, c3,
                                 input logic [ROW_WIDTH-1:0] ki_word);
        wait_drained();
        for (int n = 0; n < NUM_ROWS; n++) begin
            write_reg(lqr_ios_pkg::t_cfg_idx'(n), pack3(c1, c2, c3));
        end
        write_reg(lqr_ios_pkg::CFG_KI, ki_word);
        end_writes();
    endtask

    task automatic apply_setting(input t_coef_mix mix);
        logic [ROW_WIDTH-1:0] ki_word;
        wait_drained();
        for (int n = 0; n < NUM_ROWS; n++) begin
            write_reg(lqr_ios_pkg::t_cfg_idx'(n),
                      pack3(rand_coef(mix), rand_coef(mix), rand_coef(mix)));
        end
        // bits above the gain width are ignored by the unit
        ki_word = ROW_WIDTH'({$urandom, $urandom});
        ki_word[COEF_WIDTH-1:0] = rand_coef(mix);
        write_reg(lqr_ios_pkg::CFG_KI, ki_word);
        end_writes();
    endtask

    task automatic test_zero_gains();
        send_sample('0, '0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('1, SAMPLE_WIDTH'(1));
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
    endtask

    task automatic test_saturating_gains();
        apply_uniform(COEF_MAX, COEF_MAX, COEF_MAX, {{(ROW_WIDTH-COEF_WIDTH){1'b1}}, COEF_MAX});
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, '0);
        apply_uniform(COEF_MIN, COEF_MIN, COEF_MIN, {{(ROW_WIDTH-COEF_WIDTH){1'b0}}, COEF_MIN});
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample('0, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, '0);
        send_sample('1, '1);
    endtask

    task automatic test_mixed_gains();
        apply_uniform(COEF_MAX, COEF_MIN, '1, ROW_WIDTH'(COEF_ONE));
        send_sample(SAMPLE_WIDTH'(32'h0001_0000), '0);
        send_sample('0, SAMPLE_WIDTH'(32'h0001_0000));
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('1, SAMPLE_MIN);
    endtask

    task automatic test_settle_pause();
        apply_setting(MIX_SMALL);
        for (int n = 0; n < 10; n++) begin
            send_sample(rand_sample(), rand_sample());
        end
        wait_drained();
        for (int n = 0; n < 10; n++) begin
            send_sample(rand_sample(), rand_sample());
        end
    endtask

    task automatic test_random_settings();
        t_coef_mix mix;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 2 == 0) begin
                mix = MIX_SMALL;
            end else if (ph % 4 == 1) begin
                mix = MIX_FULL;
            end else begin
                mix = MIX_EDGE;
            end
            apply_setting(mix);
            idle_on = (ph != 6);
            for (int n = 0; n < 110; n++) begin
                send_sample(rand_sample(), rand_sample());
            end
        end
        idle_on = 1'b1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_drive_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result: drive %h flag %b", $time, m_axis_tdata,
                         m_axis_tuser);
            end else begin
                exp_res = drive_q.pop_front();
                if (m_axis_tdata !== exp_res.drive) begin
                    err_cnt++;
                    $display("%0t: drive mismatch: expected %h actual %h", $time,
                             exp_res.drive, m_axis_tdata);
                end
                if (m_axis_tuser !== exp_res.clipped) begin
                    err_cnt++;
                    $display("%0t: saturated mismatch: expected %b actual %b", $time,
                             exp_res.clipped, m_axis_tuser);
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(3999) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1000, 1)) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 11);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        for (int n = 0; n < NUM_ROWS; n++) begin
            coef_row[n] = '0;
        end
        ki_gain   = '0;
        est_x     = '{default: '0};
        err_integ = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_gains();
        test_saturating_gains();
        test_mixed_gains();
        test_settle_pause();
        test_random_settings();

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
design/lqr_ios_pkg.sv
design/lqr_integral_observer_step_unit.sv
design/lqr_ios_chk.sv
tb/lqr_integral_observer_step_unit_tb.sv
